/* sv/line_clip_region_codes_macros.svh */
// assertion macros for the line clipping block
`ifndef LINE_CLIP_REGION_CODES_MACROS_SVH
`define LINE_CLIP_REGION_CODES_MACROS_SVH
`ifndef SYNTH
`define LCRC_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("line clip assertion failed");
`define LCRC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("line clip assertion failed");
`else
`define LCRC_ASSERT_NOW(label, clk, rst, ante, cons)
`define LCRC_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

/* sv/lcrc_pkg.sv */
// shared codes, constants and control types for the line clipping block
package lcrc_pkg;

  localparam logic [3:0] CODE_LEFT   = 4'd1;
  localparam logic [3:0] CODE_RIGHT  = 4'd2;
  localparam logic [3:0] CODE_BOTTOM = 4'd4;
  localparam logic [3:0] CODE_TOP    = 4'd8;

  localparam int MAX_PASSES = 4;
  localparam int PASS_W     = $clog2(MAX_PASSES + 1);

  localparam int CFG_INDEX_W = 2;
  localparam logic [CFG_INDEX_W-1:0] REG_LEFT   = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] REG_BOTTOM = CFG_INDEX_W'(1);
  localparam logic [CFG_INDEX_W-1:0] REG_RIGHT  = CFG_INDEX_W'(2);
  localparam logic [CFG_INDEX_W-1:0] REG_TOP    = CFG_INDEX_W'(3);

  localparam int RESET_LEFT   = 100;
  localparam int RESET_BOTTOM = 200;
  localparam int RESET_RIGHT  = 500;
  localparam int RESET_TOP    = 500;

  typedef struct packed {
    logic load;
    logic setup;
    logic mul;
    logic div_start;
    logic write;
    logic emit;
    logic accept;
  } cmd_t;

  typedef struct packed {
    logic clear;
    logic overlap;
    logic div_done;
    logic out_free;
  } stat_t;

endpackage

/* sv/line_clip_region_codes.sv */
// top level of the region code line clipper
// Clips one segment per request against the window in four registers
// (left, bottom, right, top). A request makes P clip passes, zero to four.
// Each pass chooses the edge, does the multiply, starts the divider, waits on
// the shared serial divider (one quotient bit a cycle) and writes the moved
// endpoint. One segment is in work at a time. The result sits in an output
// register, so the next segment can be taken while it waits.
// Window writes are always ready and belong between requests.
`include "line_clip_region_codes_macros.svh"

module line_clip_region_codes #(
  parameter int COORD_BITS = 12
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [COORD_BITS-1:0]        start_x,
  input  logic signed [COORD_BITS-1:0]        start_y,
  input  logic signed [COORD_BITS-1:0]        end_x,
  input  logic signed [COORD_BITS-1:0]        end_y,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                accepted,
  output logic signed [COORD_BITS-1:0]        clipped_start_x,
  output logic signed [COORD_BITS-1:0]        clipped_start_y,
  output logic signed [COORD_BITS-1:0]        clipped_end_x,
  output logic signed [COORD_BITS-1:0]        clipped_end_y,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [lcrc_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [COORD_BITS-1:0]               cfg_data
);

  lcrc_pkg::cmd_t  cmd;
  lcrc_pkg::stat_t stat;

  assign cfg_ready = 1'b1;

  lcrc_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .stat    (stat),
    .cmd     (cmd)
  );

  lcrc_dp #(
    .COORD_BITS(COORD_BITS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .cfg_we         (cfg_valid && cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .start_x        (start_x),
    .start_y        (start_y),
    .end_x          (end_x),
    .end_y          (end_y),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .accepted       (accepted),
    .clipped_start_x(clipped_start_x),
    .clipped_start_y(clipped_start_y),
    .clipped_end_x  (clipped_end_x),
    .clipped_end_y  (clipped_end_y)
  );

  // a taken request keeps the input side closed while it is clipped
  `LCRC_ASSERT_NEXT(a_busy_after_take, clk, rst, in_valid && !in_stall, in_stall)
  // a clip pass only writes an endpoint right after the divider finishes
  `LCRC_ASSERT_NOW(a_write_after_div, clk, rst, cmd.write, $past(stat.div_done))
  // a finished request always shows up at the output
  `LCRC_ASSERT_NEXT(a_emit_shows, clk, rst, cmd.emit, out_valid && (accepted == $past(cmd.accept)))

endmodule

/* sv/lcrc_div.sv */
// serial restoring divider on magnitudes, one quotient bit per cycle
module lcrc_div #(
  parameter int NUM_W = 24,
  parameter int DEN_W = 12
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quo
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic             busy;
  logic [CNT_W-1:0] count;
  logic [DEN_W-1:0] rem;
  logic [DEN_W:0]   trial;
  logic             fits;

  assign trial = {rem, quo[NUM_W-1]};
  assign fits  = trial >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= CNT_W'(NUM_W);
      end else if (busy) begin
        count <= count - CNT_W'(1);
        if (count == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // dividend bits shift out of quo as quotient bits shift in
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= num;
    end else if (busy) begin
      if (fits) begin
        rem <= DEN_W'(trial - {1'b0, den});
      end else begin
        rem <= trial[DEN_W-1:0];
      end
      quo <= {quo[NUM_W-2:0], fits};
    end
  end

endmodule

/* sv/lcrc_ctrl.sv */
// pass sequencer for the line clipping block
module lcrc_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  lcrc_pkg::stat_t stat,
  output lcrc_pkg::cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_MUL,
    S_DIV_START,
    S_DIV_WAIT,
    S_WRITE,
    S_FINISH
  } state_t;

  state_t                      state;
  logic [lcrc_pkg::PASS_W-1:0] pass_cnt;
  logic                        accept_flag;
  logic                        at_limit;
  logic                        go_on;

  assign at_limit = pass_cnt == lcrc_pkg::PASS_W'(lcrc_pkg::MAX_PASSES);
  assign go_on    = !stat.clear && !stat.overlap && !at_limit;
  assign in_stall = state != S_IDLE;

  always_comb begin
    cmd           = '0;
    cmd.load      = (state == S_IDLE) && in_valid;
    cmd.setup     = (state == S_CHECK) && go_on;
    cmd.mul       = state == S_MUL;
    cmd.div_start = state == S_DIV_START;
    cmd.write     = state == S_WRITE;
    cmd.emit      = (state == S_FINISH) && stat.out_free;
    cmd.accept    = accept_flag;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      pass_cnt    <= '0;
      accept_flag <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            pass_cnt <= '0;
            state    <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (stat.clear) begin
            accept_flag <= 1'b1;
            state       <= S_FINISH;
          end else if (stat.overlap || at_limit) begin
            accept_flag <= 1'b0;
            state       <= S_FINISH;
          end else begin
            pass_cnt <= pass_cnt + lcrc_pkg::PASS_W'(1);
            state    <= S_MUL;
          end
        end
        S_MUL:       state <= S_DIV_START;
        S_DIV_START: state <= S_DIV_WAIT;
        S_DIV_WAIT: begin
          if (stat.div_done) begin
            state <= S_WRITE;
          end
        end
        S_WRITE:     state <= S_CHECK;
        S_FINISH: begin
          if (stat.out_free) begin
            state <= S_IDLE;
          end
        end
        default:     state <= S_IDLE;
      endcase
    end
  end

endmodule

/* sv/lcrc_dp.sv */
// endpoint registers, window registers, intersection arithmetic and result register
module lcrc_dp #(
  parameter int COORD_BITS = 12
) (
  input  logic                                clk,
  input  logic                                rst,
  input  lcrc_pkg::cmd_t                      cmd,
  output lcrc_pkg::stat_t                     stat,
  input  logic                                cfg_we,
  input  logic [lcrc_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [COORD_BITS-1:0]               cfg_data,
  input  logic signed [COORD_BITS-1:0]        start_x,
  input  logic signed [COORD_BITS-1:0]        start_y,
  input  logic signed [COORD_BITS-1:0]        end_x,
  input  logic signed [COORD_BITS-1:0]        end_y,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                accepted,
  output logic signed [COORD_BITS-1:0]        clipped_start_x,
  output logic signed [COORD_BITS-1:0]        clipped_start_y,
  output logic signed [COORD_BITS-1:0]        clipped_end_x,
  output logic signed [COORD_BITS-1:0]        clipped_end_y
);

  localparam int C      = COORD_BITS;
  localparam int DIFF_W = C + 1;
  localparam int PROD_W = 2 * C + 2;
  localparam int MAG_W  = 2 * C;
  localparam int QUO_W  = 2 * C + 1;
  localparam int SUM_W  = 2 * C + 2;

  logic signed [C-1:0] clip_left, clip_bottom, clip_right, clip_top;
  logic signed [C-1:0] x1, y1, x2, y2;
  logic signed [C-1:0] base, bound_val;
  logic signed [DIFF_W-1:0] mul_a, mul_b, divisor;
  logic signed [PROD_W-1:0] prod;
  logic edge_is_y, tgt_first, q_neg, div_zero;

  logic [3:0] c1, c2, co;
  logic signed [C-1:0] base_next, bound_next;
  logic signed [DIFF_W-1:0] a_next, b_next, e_next;
  logic edge_is_y_next;
  logic [PROD_W-1:0] prod_mag;
  logic [DIFF_W-1:0] den_mag;
  logic [MAG_W-1:0] quo;
  logic div_done;
  logic signed [QUO_W-1:0] q_val;
  logic signed [SUM_W-1:0] sum;
  logic signed [C-1:0] sat_val, nx, ny;
  logic in_range;

  function automatic logic signed [DIFF_W-1:0] wide(input logic signed [C-1:0] v);
    return {v[C-1], v};
  endfunction

  function automatic logic [3:0] outcode(
    input logic signed [C-1:0] x,
    input logic signed [C-1:0] y,
    input logic signed [C-1:0] xl,
    input logic signed [C-1:0] yb,
    input logic signed [C-1:0] xr,
    input logic signed [C-1:0] yt
  );
    logic [3:0] c;
    c = '0;
    if (x < xl) begin
      c = c | lcrc_pkg::CODE_LEFT;
    end else if (x > xr) begin
      c = c | lcrc_pkg::CODE_RIGHT;
    end
    if (y < yb) begin
      c = c | lcrc_pkg::CODE_BOTTOM;
    end else if (y > yt) begin
      c = c | lcrc_pkg::CODE_TOP;
    end
    return c;
  endfunction

  assign c1 = outcode(x1, y1, clip_left, clip_bottom, clip_right, clip_top);
  assign c2 = outcode(x2, y2, clip_left, clip_bottom, clip_right, clip_top);
  assign co = (c1 != 4'd0) ? c1 : c2;

  // edge chosen in the order top, bottom, right, left
  always_comb begin
    base_next      = x1;
    a_next         = wide(x2) - wide(x1);
    b_next         = wide(clip_top) - wide(y1);
    e_next         = wide(y2) - wide(y1);
    bound_next     = clip_top;
    edge_is_y_next = 1'b1;
    if ((co & lcrc_pkg::CODE_TOP) != 4'd0) begin
      b_next     = wide(clip_top) - wide(y1);
      bound_next = clip_top;
    end else if ((co & lcrc_pkg::CODE_BOTTOM) != 4'd0) begin
      b_next     = wide(clip_bottom) - wide(y1);
      bound_next = clip_bottom;
    end else begin
      base_next      = y1;
      a_next         = wide(y2) - wide(y1);
      e_next         = wide(x2) - wide(x1);
      edge_is_y_next = 1'b0;
      if ((co & lcrc_pkg::CODE_RIGHT) != 4'd0) begin
        b_next     = wide(clip_right) - wide(x1);
        bound_next = clip_right;
      end else begin
        b_next     = wide(clip_left) - wide(x1);
        bound_next = clip_left;
      end
    end
  end

  assign prod_mag = prod[PROD_W-1] ? PROD_W'(-prod) : PROD_W'(prod);
  assign den_mag  = divisor[DIFF_W-1] ? DIFF_W'(-divisor) : DIFF_W'(divisor);

  lcrc_div #(
    .NUM_W(MAG_W),
    .DEN_W(C)
  ) u_div (
    .clk  (clk),
    .rst  (rst),
    .start(cmd.div_start),
    .num  (prod_mag[MAG_W-1:0]),
    .den  (den_mag[C-1:0]),
    .done (div_done),
    .quo  (quo)
  );

  // signed quotient, truncated toward zero, then saturated sum
  always_comb begin
    if (div_zero) begin
      q_val = '0;
    end else if (q_neg) begin
      q_val = -$signed({1'b0, quo});
    end else begin
      q_val = $signed({1'b0, quo});
    end
    sum      = SUM_W'(base) + SUM_W'(q_val);
    in_range = (&sum[SUM_W-1:C-1]) || !(|sum[SUM_W-1:C-1]);
    if (in_range) begin
      sat_val = sum[C-1:0];
    end else if (sum[SUM_W-1]) begin
      sat_val = {1'b1, {(C-1){1'b0}}};
    end else begin
      sat_val = {1'b0, {(C-1){1'b1}}};
    end
    nx = edge_is_y ? sat_val : bound_val;
    ny = edge_is_y ? bound_val : sat_val;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clip_left   <= C'(lcrc_pkg::RESET_LEFT);
      clip_bottom <= C'(lcrc_pkg::RESET_BOTTOM);
      clip_right  <= C'(lcrc_pkg::RESET_RIGHT);
      clip_top    <= C'(lcrc_pkg::RESET_TOP);
    end else if (cfg_we) begin
      unique case (cfg_index)
        lcrc_pkg::REG_LEFT:   clip_left   <= cfg_data;
        lcrc_pkg::REG_BOTTOM: clip_bottom <= cfg_data;
        lcrc_pkg::REG_RIGHT:  clip_right  <= cfg_data;
        lcrc_pkg::REG_TOP:    clip_top    <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x1 <= start_x;
      y1 <= start_y;
      x2 <= end_x;
      y2 <= end_y;
    end else if (cmd.write) begin
      if (tgt_first) begin
        x1 <= nx;
        y1 <= ny;
      end else begin
        x2 <= nx;
        y2 <= ny;
      end
    end
    if (cmd.setup) begin
      base      <= base_next;
      bound_val <= bound_next;
      mul_a     <= a_next;
      mul_b     <= b_next;
      divisor   <= e_next;
      edge_is_y <= edge_is_y_next;
      tgt_first <= c1 != 4'd0;
    end
    if (cmd.mul) begin
      prod <= PROD_W'(mul_a) * PROD_W'(mul_b);
    end
    if (cmd.div_start) begin
      q_neg    <= prod[PROD_W-1] ^ divisor[DIFF_W-1];
      div_zero <= divisor == '0;
    end
    if (cmd.emit) begin
      accepted        <= cmd.accept;
      clipped_start_x <= x1;
      clipped_start_y <= y1;
      clipped_end_x   <= x2;
      clipped_end_y   <= y2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  assign stat.clear    = (c1 == 4'd0) && (c2 == 4'd0);
  assign stat.overlap  = (c1 & c2) != 4'd0;
  assign stat.div_done = div_done;
  assign stat.out_free = !out_valid || !out_stall;

endmodule
